FILE: hw/rtl/rc4v_pkg.sv
// Shared types and constants for the RC4-variant stream cipher core.
// No dependencies; imported by every RTL module of the block.
package rc4v_pkg;

  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_DATA    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_READY    = 2'd1;
  localparam logic [1:0] STATUS_CRYPTED  = 2'd2;
  localparam logic [1:0] STATUS_ERROR    = 2'd3;

  localparam logic [7:0] KEY_MASK = 8'hAA;
  localparam int unsigned PERM_W = 8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_in;
    logic       last_key;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POST,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WI,
    ST_KS_WJ,
    ST_COPY,
    ST_D_RX,
    ST_D_RY,
    ST_D_RT,
    ST_D_RO,
    ST_D_OUT
  } state_t;

endpackage

FILE: hw/rtl/rc4v_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is a parameter; the core uses rc4v_pkg item types.
interface rc4v_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rc4_variant_stream_cipher_core.sv
// RC4-variant stream cipher core. A key byte is stored and answered via ST_POST;
// a data byte runs ST_D_RX to ST_D_OUT, restart copies the saved table (ST_COPY), and the
// final key byte fills the table (ST_INIT), then runs the key schedule on the permutation RAM.
// One transaction in flight; the next is taken once the result is registered.
// Transactions are serialized, as the permutation RAM has one read port.
// Reset (synchronous, rst high) clears control, the x and y indices and key count; j, k and RAMs are not cleared.
module rc4_variant_stream_cipher_core import rc4v_pkg::*; #(
  parameter int unsigned KEY_BYTES_MAX = 255
) (
  input  logic               clk,
  input  logic               rst,
  rc4v_stream_if.sink        item,
  rc4v_stream_if.source      result
);
  localparam int unsigned KW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int unsigned CW = $clog2(KEY_BYTES_MAX + 1);

  state_t state, state_next;

  logic          keyed;
  logic [CW-1:0] key_count;
  logic [CW-1:0] key_len;
  logic [7:0]    x, y, j;
  logic [KW-1:0] k;
  logic [8:0]    cnt;
  logic [7:0]    din_q, si, b_reg, c_reg;
  logic          hit;
  logic [7:0]    res_data;
  logic [1:0]    res_status;
  logic          out_valid;
  out_item_t     out_q;

  in_item_t      in_p;
  logic          accept, out_free, key_full;
  logic [CW-1:0] count_inc, k_inc;
  state_t        dec_next;
  logic [1:0]    dec_status;
  logic          dec_seed_we;

  logic          w_we, s_we, k_we;
  logic [7:0]    w_waddr, w_wdata, w_raddr, w_rdata;
  logic [7:0]    s_raddr, s_rdata;
  logic [KW-1:0] k_raddr;
  logic [7:0]    k_rdata;

  logic [7:0]    j_new, y_new, c_val, v1, idx, ks_out;

  assign in_p      = item.payload;
  assign item.ready = (state == ST_IDLE);
  assign accept    = item.valid && item.ready;
  assign out_free  = !out_valid || result.ready;
  assign key_full  = key_count >= CW'(KEY_BYTES_MAX);
  assign count_inc = key_count + CW'(1);
  assign k_inc     = CW'(k) + CW'(1);

  assign result.valid   = out_valid;
  assign result.payload = out_q;

  assign j_new  = j + k_rdata + w_rdata;
  assign y_new  = y + w_rdata;
  assign c_val  = (si == x) ? b_reg : w_rdata;
  assign v1     = (x == y) ? c_val : b_reg;
  assign idx    = v1 + c_val;
  assign ks_out = hit ? c_reg : w_rdata;

  rc4v_ram #(.ADDR_W(8), .DATA_W(PERM_W)) u_working (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  rc4v_ram #(.ADDR_W(8), .DATA_W(PERM_W)) u_saved (
    .clk(clk), .we(s_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  rc4v_ram #(.ADDR_W(KW), .DATA_W(8)) u_seed (
    .clk(clk), .we(k_we), .waddr(key_count[KW-1:0]), .wdata(in_p.data_in | KEY_MASK),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  // Decode of an incoming transaction
  always_comb begin
    dec_next    = ST_POST;
    dec_status  = STATUS_ERROR;
    dec_seed_we = 1'b0;
    unique case (in_p.mode)
      MODE_KEY: begin
        if (!key_full) begin
          dec_seed_we = 1'b1;
          if (in_p.last_key) begin
            dec_next = ST_INIT;
          end else begin
            dec_status = STATUS_ACCEPTED;
          end
        end
      end
      MODE_DATA: begin
        if (keyed) begin
          dec_next = ST_D_RX;
        end
      end
      MODE_RESTART: begin
        if (keyed) begin
          dec_next = ST_COPY;
        end
      end
      default: begin
        dec_next = ST_POST;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (item.valid) state_next = dec_next;
      ST_POST:  if (out_free) state_next = ST_IDLE;
      ST_INIT:  if (cnt[7:0] == 8'hFF) state_next = ST_KS_RD;
      ST_KS_RD: state_next = ST_KS_J;
      ST_KS_J:  state_next = ST_KS_WI;
      ST_KS_WI: state_next = ST_KS_WJ;
      ST_KS_WJ: state_next = (cnt[7:0] == 8'hFF) ? ST_POST : ST_KS_RD;
      ST_COPY:  if (cnt[8]) state_next = ST_POST;
      ST_D_RX:  state_next = ST_D_RY;
      ST_D_RY:  state_next = ST_D_RT;
      ST_D_RT:  state_next = ST_D_RO;
      ST_D_RO:  state_next = ST_D_OUT;
      ST_D_OUT: state_next = ST_POST;
      default:  state_next = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    w_we    = 1'b0;
    s_we    = 1'b0;
    k_we    = 1'b0;
    w_waddr = cnt[7:0];
    w_wdata = cnt[7:0];
    w_raddr = cnt[7:0];
    s_raddr = cnt[7:0];
    k_raddr = k;
    unique case (state)
      ST_IDLE: k_we = accept && dec_seed_we;
      ST_INIT: begin
        w_we = 1'b1;
        s_we = 1'b1;
      end
      ST_KS_J: w_raddr = j_new;
      ST_KS_WI: begin
        w_we    = 1'b1;
        s_we    = 1'b1;
        w_wdata = w_rdata;
      end
      ST_KS_WJ: begin
        w_we    = 1'b1;
        s_we    = 1'b1;
        w_waddr = j;
        w_wdata = si;
      end
      ST_COPY: begin
        w_we    = (cnt != 9'd0);
        w_waddr = cnt[7:0] - 8'd1;
        w_wdata = s_rdata;
      end
      ST_D_RX: w_raddr = x + 8'd1;
      ST_D_RY: w_raddr = y_new;
      ST_D_RT: begin
        w_we    = 1'b1;
        w_waddr = x;
        w_wdata = w_rdata;
        w_raddr = si;
      end
      ST_D_RO: begin
        w_we    = 1'b1;
        w_waddr = y;
        w_wdata = c_val;
        w_raddr = idx;
      end
      default: w_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      keyed     <= 1'b0;
      key_count <= '0;
      x         <= '0;
      y         <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_POST && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept && in_p.mode == MODE_KEY) begin
            if (key_full) begin
              if (in_p.last_key) key_count <= '0;
            end else begin
              key_count <= in_p.last_key ? '0 : count_inc;
            end
          end
        end
        ST_INIT: begin
          cnt <= (cnt[7:0] == 8'hFF) ? 9'd0 : cnt + 9'd1;
          x   <= '0;
          y   <= '0;
        end
        ST_KS_WJ: begin
          cnt <= cnt + 9'd1;
          if (cnt[7:0] == 8'hFF) keyed <= 1'b1;
        end
        ST_COPY: begin
          cnt <= cnt + 9'd1;
          if (cnt[8]) begin
            x <= '0;
            y <= '0;
          end
        end
        ST_D_RX:  x <= x + 8'd1;
        ST_D_RY:  y <= y_new;
        default:  cnt <= cnt;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          din_q      <= in_p.data_in;
          res_data   <= '0;
          res_status <= dec_status;
          key_len    <= count_inc;
        end
      end
      ST_POST: if (out_free) out_q <= '{data_out: res_data, status: res_status};
      ST_INIT: begin
        j <= '0;
        k <= '0;
      end
      ST_KS_J: begin
        j  <= j_new;
        si <= w_rdata;
      end
      ST_KS_WJ: begin
        k <= (k_inc == key_len) ? '0 : k_inc[KW-1:0];
        if (cnt[7:0] == 8'hFF) res_status <= STATUS_READY;
      end
      ST_COPY:  res_status <= STATUS_READY;
      ST_D_RY:  si <= w_rdata;
      ST_D_RT:  b_reg <= w_rdata;
      ST_D_RO: begin
        c_reg <= c_val;
        hit   <= (idx == y);
      end
      ST_D_OUT: begin
        res_data   <= din_q ^ ks_out;
        res_status <= STATUS_CRYPTED;
      end
      default: hit <= hit;
    endcase
  end
endmodule

FILE: hw/rtl/rc4v_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
// Imports rc4v_pkg; the default data width is a literal 8, not taken from the package.
module rc4v_ram import rc4v_pkg::*; #(
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
